// ===== rtl/rrs_pkg.sv =====
// shared types and constants for the tx/rx relay sequencer
package rrs_pkg;

    localparam int SAMPLES_PER_AVERAGE = 32;
    localparam int AVERAGE_SHIFT_BITS  = 7;
    localparam int BLINK_PERIOD_TICKS  = 200;

    localparam int SAMPLE_W = 10;
    localparam int TICK_W   = 16;
    localparam int GOOD_W   = 8;
    localparam int SUM_W    = 15;
    localparam int CNT_W    = 6;
    localparam int DELAY_W  = 10;
    localparam int MODE_W   = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [TICK_W-1:0]  BLINK_FULL = TICK_W'(BLINK_PERIOD_TICKS);
    localparam logic [TICK_W-1:0]  BLINK_HALF = TICK_W'(BLINK_PERIOD_TICKS / 2);
    localparam logic [CNT_W:0]     AVG_COUNT  = (CNT_W + 1)'(SAMPLES_PER_AVERAGE);
    localparam logic [DELAY_W-1:0] DELAY_MAX  = {DELAY_W{1'b1}};

    // mode codes
    localparam logic [MODE_W-1:0] MODE_STARTUP    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RX         = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PREAMP_OFF = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RELAY_ON   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TX         = 3'd4;
    localparam logic [MODE_W-1:0] MODE_AMP_OFF    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RELAY_OFF  = 3'd6;

    // item commands
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_PTT  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GOOD_PERIODS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MINIMUM_DELAY    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DELAY    = 2'd3;

    // relay and led bit positions
    localparam int RLY_PRE = 0;
    localparam int RLY_ANT = 1;
    localparam int RLY_AMP = 2;
    localparam int LED_PWR = 0;
    localparam int LED_PTT = 1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] supply_threshold;
        logic [GOOD_W-1:0]   good_periods_needed;
        logic [DELAY_W-1:0]  minimum_delay;
        logic [DELAY_W-1:0]  initial_delay;
    } t_cfg;

    typedef struct packed {
        logic                cmd;
        logic [SAMPLE_W-1:0] adc_sample;
        logic                ptt_level;
    } t_item;

    typedef struct packed {
        logic              relay_preamp;
        logic              relay_antenna;
        logic              relay_amplifier;
        logic              power_led;
        logic              ptt_led;
        logic [MODE_W-1:0] mode;
        logic              sample_source;
    } t_result;

endpackage

// ===== rtl/rrs_cfg_regs.sv =====
// configuration register file for the relay sequencer
module rrs_cfg_regs
    import rrs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SAMPLE_W-1:0]  i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SUPPLY_THRESHOLD: n_cfg.supply_threshold    = i_cfg_data;
                CFG_GOOD_PERIODS:     n_cfg.good_periods_needed = i_cfg_data[GOOD_W-1:0];
                CFG_MINIMUM_DELAY:    n_cfg.minimum_delay       = i_cfg_data;
                CFG_INITIAL_DELAY:    n_cfg.initial_delay       = i_cfg_data;
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.supply_threshold    <= 10'd890;
            r_cfg.good_periods_needed <= 8'd8;
            r_cfg.minimum_delay       <= 10'd70;
            r_cfg.initial_delay       <= 10'd200;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== rtl/rrs_core.sv =====
// sequencer state and the per-item update logic
module rrs_core
    import rrs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [MODE_W-1:0]   r_mode, n_mode;
    logic [TICK_W-1:0]   r_tick, n_tick;
    logic [GOOD_W-1:0]   r_good, n_good;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [DELAY_W-1:0]  r_delay, n_delay;
    logic [2:0]          r_relay, n_relay;
    logic [1:0]          r_led, n_led;

    logic                low;
    logic [TICK_W-1:0]   tick_inc;
    logic [CNT_W:0]      cnt_inc;
    logic [SUM_W-1:0]    sum_add;
    logic [TICK_W-1:0]   delay_sum;

    assign low       = i_item.adc_sample < i_cfg.supply_threshold;
    assign tick_inc  = r_tick + 1'b1;
    assign cnt_inc   = {1'b0, r_cnt} + 1'b1;
    assign sum_add   = r_sum + SUM_W'(i_item.adc_sample);
    assign delay_sum = TICK_W'(sum_add >> AVERAGE_SHIFT_BITS) + TICK_W'(i_cfg.minimum_delay);

    always_comb begin
        n_mode  = r_mode;
        n_tick  = r_tick;
        n_good  = r_good;
        n_sum   = r_sum;
        n_cnt   = r_cnt;
        n_delay = r_delay;
        n_relay = r_relay;
        n_led   = r_led;

        if (i_item.cmd == CMD_TICK && r_mode == MODE_STARTUP) begin
            n_tick = tick_inc;
            if (low) begin
                n_good = '0;
            end
            if (tick_inc == BLINK_HALF) begin
                n_led[LED_PWR] = 1'b1;
                n_led[LED_PTT] = 1'b0;
            end
            if (tick_inc == BLINK_FULL) begin
                n_good = n_good + 1'b1;
                n_tick = '0;
                if (n_good == i_cfg.good_periods_needed) begin
                    n_good  = '0;
                    n_delay = i_cfg.initial_delay;
                    if (i_item.ptt_level) begin
                        n_led[LED_PTT]   = 1'b0;
                        n_relay[RLY_PRE] = 1'b1;
                        n_mode           = MODE_RX;
                    end else begin
                        n_led[LED_PTT]   = 1'b1;
                        n_relay[RLY_ANT] = 1'b1;
                        n_mode           = MODE_RELAY_ON;
                    end
                end else begin
                    n_led[LED_PWR] = 1'b0;
                    if (low) begin
                        n_led[LED_PTT] = 1'b1;
                    end
                end
            end
        end else if (i_item.cmd == CMD_TICK) begin
            // potentiometer averaging sets the step delay
            if (cnt_inc == AVG_COUNT) begin
                n_delay = (delay_sum > TICK_W'(DELAY_MAX)) ? DELAY_MAX
                                                           : delay_sum[DELAY_W-1:0];
                n_sum   = '0;
                n_cnt   = '0;
            end else begin
                n_sum = sum_add;
                n_cnt = cnt_inc[CNT_W-1:0];
            end
            n_tick = tick_inc;
            if (tick_inc == TICK_W'(n_delay)) begin
                unique case (r_mode)
                    MODE_AMP_OFF: begin
                        n_relay[RLY_ANT] = 1'b0;
                        n_mode           = MODE_RELAY_OFF;
                    end
                    MODE_RELAY_OFF: begin
                        n_relay[RLY_PRE] = 1'b1;
                        n_mode           = MODE_RX;
                    end
                    MODE_PREAMP_OFF: begin
                        n_relay[RLY_ANT] = 1'b1;
                        n_mode           = MODE_RELAY_ON;
                    end
                    MODE_RELAY_ON: begin
                        n_relay[RLY_AMP] = 1'b1;
                        n_mode           = MODE_TX;
                    end
                    default: n_mode = r_mode;
                endcase
                n_tick = '0;
            end
        end else if (r_mode != MODE_STARTUP) begin
            n_tick = '0;
            if (i_item.ptt_level) begin
                n_led[LED_PTT] = 1'b0;
                unique case (r_mode)
                    MODE_PREAMP_OFF: begin
                        n_relay[RLY_PRE] = 1'b1;
                        n_mode           = MODE_RX;
                    end
                    MODE_RELAY_ON: begin
                        n_relay[RLY_ANT] = 1'b0;
                        n_mode           = MODE_RELAY_OFF;
                    end
                    MODE_TX: begin
                        n_relay[RLY_AMP] = 1'b0;
                        n_mode           = MODE_AMP_OFF;
                    end
                    default: n_mode = r_mode;
                endcase
            end else begin
                n_led[LED_PTT] = 1'b1;
                unique case (r_mode)
                    MODE_AMP_OFF: begin
                        n_relay[RLY_AMP] = 1'b1;
                        n_mode           = MODE_TX;
                    end
                    MODE_RELAY_OFF: begin
                        n_relay[RLY_ANT] = 1'b1;
                        n_mode           = MODE_RELAY_ON;
                    end
                    MODE_RX: begin
                        n_relay[RLY_PRE] = 1'b0;
                        n_mode           = MODE_PREAMP_OFF;
                    end
                    default: n_mode = r_mode;
                endcase
            end
        end
    end

    // result shows the state after the item
    always_comb begin
        o_result.relay_preamp    = n_relay[RLY_PRE];
        o_result.relay_antenna   = n_relay[RLY_ANT];
        o_result.relay_amplifier = n_relay[RLY_AMP];
        o_result.power_led       = n_led[LED_PWR];
        o_result.ptt_led         = n_led[LED_PTT];
        o_result.mode            = n_mode;
        o_result.sample_source   = (n_mode != MODE_STARTUP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_STARTUP;
            r_tick  <= '0;
            r_good  <= '0;
            r_sum   <= '0;
            r_cnt   <= '0;
            r_delay <= 10'd200;
            r_relay <= '0;
            r_led   <= '0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_tick  <= n_tick;
            r_good  <= n_good;
            r_sum   <= n_sum;
            r_cnt   <= n_cnt;
            r_delay <= n_delay;
            r_relay <= n_relay;
            r_led   <= n_led;
        end
    end

`ifndef SYNTH
    // relay patterns tied to the settled modes
    a_startup_relays_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_STARTUP |-> r_relay == 3'b000)
        else $error("relay energised during startup");

    a_rx_relays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_RX |-> r_relay == 3'b001)
        else $error("receive mode with wrong relay pattern");

    a_tx_relays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_TX |-> r_relay == 3'b110)
        else $error("transmit mode with wrong relay pattern");

    a_no_return_to_startup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != MODE_STARTUP |=> r_mode != MODE_STARTUP)
        else $error("sequencer fell back into startup");
`endif

endmodule

// ===== rtl/tx_rx_relay_sequencer_unit.sv =====
// top level of the tx/rx relay sequencer: input register, core, result register
// an accepted beat is held in the input register until its result enters the result register
// throughput: one beat per cycle while i_stall is low, set by the state update in rrs_core
// the result register lets a new beat enter while a finished result waits
// reset (synchronous, active low): startup mode, relays and leds off, registers at defaults
module tx_rx_relay_sequencer_unit
    import rrs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_cmd,
    input  logic [SAMPLE_W-1:0]  i_adc_sample,
    input  logic                 i_ptt_level,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_relay_preamp,
    output logic                 o_relay_antenna,
    output logic                 o_relay_amplifier,
    output logic                 o_power_led,
    output logic                 o_ptt_led,
    output logic [MODE_W-1:0]    o_mode,
    output logic                 o_sample_source,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SAMPLE_W-1:0]  i_cfg_data
);

    t_cfg    cfg;
    t_result core_result;

    logic    r_in_vld, n_in_vld;
    t_item   r_in;
    logic    r_out_vld;
    t_result r_out;
    logic    advance;
    logic    in_take;

    rrs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rrs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    // held beat moves on when the result register is free or draining
    assign advance = r_in_vld && (!r_out_vld || !i_stall);
    assign o_stall = r_in_vld && !advance;
    assign in_take = i_valid && !o_stall;

    always_comb begin
        n_in_vld = r_in_vld;
        if (in_take) begin
            n_in_vld = 1'b1;
        end else if (advance) begin
            n_in_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld <= n_in_vld;
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.cmd        <= i_cmd;
            r_in.adc_sample <= i_adc_sample;
            r_in.ptt_level  <= i_ptt_level;
        end
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_valid           = r_out_vld;
    assign o_relay_preamp    = r_out.relay_preamp;
    assign o_relay_antenna   = r_out.relay_antenna;
    assign o_relay_amplifier = r_out.relay_amplifier;
    assign o_power_led       = r_out.power_led;
    assign o_ptt_led         = r_out.ptt_led;
    assign o_mode            = r_out.mode;
    assign o_sample_source   = r_out.sample_source;

`ifndef SYNTH
    a_advance_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_vld)
        else $error("processed beat did not reach the result register");

    a_held_beat_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !advance |=> r_in_vld && $stable(r_in))
        else $error("waiting input beat lost or changed");

    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_vld |-> !o_stall)
        else $error("input stalled with an empty input register");
`endif

endmodule

// ===== tb/tx_rx_relay_sequencer_unit_tb.sv =====
// self-checking testbench for the tx/rx relay sequencer: directed and random beats against a predictor
module tx_rx_relay_sequencer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rrs_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_BEATS = 850;
    localparam int RUN_PHASES   = 6;
    localparam int HOLD_CYCLES  = 80;
    localparam int ERROR_PRINTS = 60;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic                 i_cmd = CMD_TICK;
    logic [SAMPLE_W-1:0]  i_adc_sample = '0;
    logic                 i_ptt_level = 1'b1;
    logic                 o_valid;
    logic                 i_stall = 1'b1;
    logic                 o_relay_preamp;
    logic                 o_relay_antenna;
    logic                 o_relay_amplifier;
    logic                 o_power_led;
    logic                 o_ptt_led;
    logic [MODE_W-1:0]    o_mode;
    logic                 o_sample_source;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_SUPPLY_THRESHOLD;
    logic [SAMPLE_W-1:0]  i_cfg_data = '0;

    tx_rx_relay_sequencer_unit u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_cmd             (i_cmd),
        .i_adc_sample      (i_adc_sample),
        .i_ptt_level       (i_ptt_level),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_relay_preamp    (o_relay_preamp),
        .o_relay_antenna   (o_relay_antenna),
        .o_relay_amplifier (o_relay_amplifier),
        .o_power_led       (o_power_led),
        .o_ptt_led         (o_ptt_led),
        .o_mode            (o_mode),
        .o_sample_source   (o_sample_source),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // predictor copy of the sequencer state and its registers
    t_cfg               seq_cfg;
    logic [MODE_W-1:0]  seq_mode;
    logic [TICK_W-1:0]  seq_ticks;
    logic [GOOD_W-1:0]  seq_good;
    logic [SUM_W-1:0]   pot_sum;
    logic [CNT_W-1:0]   pot_count;
    logic [DELAY_W-1:0] step_delay_ticks;
    logic [2:0]         relays;
    logic [1:0]         leds;
    logic [7:0]         modes_seen = '0;

    t_item   pending_events_q[$];
    t_result predicted_drive_q[$];
    t_item   drv_item;

    int  src_gap = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    int  holds_asked = 0;
    int  holds_taken = 0;
    bit  idle_off = 1'b0;
    int  beats_in = 0;
    int  results_checked = 0;
    int  cfg_writes = 0;
    int  error_count = 0;
    int  cycle_count = 0;
    logic last_level = 1'b1;

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic t_result next_relay_outputs(t_item it);
        logic             low;
        logic [CNT_W:0]   next_count;
        logic [DELAY_W:0] sum_delay;
        t_result          r;
        if (it.cmd == CMD_TICK && seq_mode == MODE_STARTUP) begin
            low = it.adc_sample < seq_cfg.supply_threshold;
            seq_ticks = seq_ticks + 1'b1;
            if (low)
                seq_good = '0;
            if (seq_ticks == BLINK_HALF) begin
                leds[LED_PWR] = 1'b1;
                leds[LED_PTT] = 1'b0;
            end
            if (seq_ticks == BLINK_FULL) begin
                seq_good  = seq_good + 1'b1;
                seq_ticks = '0;
                if (seq_good == seq_cfg.good_periods_needed) begin
                    seq_good = '0;
                    step_delay_ticks = seq_cfg.initial_delay;
                    if (it.ptt_level) begin
                        leds[LED_PTT] = 1'b0;
                        relays[RLY_PRE] = 1'b1;
                        seq_mode = MODE_RX;
                    end else begin
                        leds[LED_PTT] = 1'b1;
                        relays[RLY_ANT] = 1'b1;
                        seq_mode = MODE_RELAY_ON;
                    end
                end else begin
                    leds[LED_PWR] = 1'b0;
                    if (low)
                        leds[LED_PTT] = 1'b1;
                end
            end
        end else if (it.cmd == CMD_TICK) begin
            pot_sum = pot_sum + SUM_W'(it.adc_sample);
            next_count = {1'b0, pot_count} + 1'b1;
            if (next_count == AVG_COUNT) begin
                sum_delay = (DELAY_W + 1)'(pot_sum >> AVERAGE_SHIFT_BITS)
                          + {1'b0, seq_cfg.minimum_delay};
                step_delay_ticks = (sum_delay > {1'b0, DELAY_MAX}) ? DELAY_MAX
                                                                   : sum_delay[DELAY_W-1:0];
                pot_sum   = '0;
                pot_count = '0;
            end else begin
                pot_count = next_count[CNT_W-1:0];
            end
            seq_ticks = seq_ticks + 1'b1;
            // equality only: a delay below the running count waits for the 16-bit wrap
            if (seq_ticks == TICK_W'(step_delay_ticks)) begin
                case (seq_mode)
                    MODE_AMP_OFF: begin relays[RLY_ANT] = 1'b0; seq_mode = MODE_RELAY_OFF; end
                    MODE_RELAY_OFF: begin relays[RLY_PRE] = 1'b1; seq_mode = MODE_RX; end
                    MODE_PREAMP_OFF: begin relays[RLY_ANT] = 1'b1; seq_mode = MODE_RELAY_ON; end
                    MODE_RELAY_ON: begin relays[RLY_AMP] = 1'b1; seq_mode = MODE_TX; end
                    default: ;
                endcase
                seq_ticks = '0;
            end
        end else if (seq_mode != MODE_STARTUP) begin
            seq_ticks = '0;
            if (it.ptt_level) begin
                leds[LED_PTT] = 1'b0;
                case (seq_mode)
                    MODE_PREAMP_OFF: begin relays[RLY_PRE] = 1'b1; seq_mode = MODE_RX; end
                    MODE_RELAY_ON: begin relays[RLY_ANT] = 1'b0; seq_mode = MODE_RELAY_OFF; end
                    MODE_TX: begin relays[RLY_AMP] = 1'b0; seq_mode = MODE_AMP_OFF; end
                    default: ;
                endcase
            end else begin
                leds[LED_PTT] = 1'b1;
                case (seq_mode)
                    MODE_AMP_OFF: begin relays[RLY_AMP] = 1'b1; seq_mode = MODE_TX; end
                    MODE_RELAY_OFF: begin relays[RLY_ANT] = 1'b1; seq_mode = MODE_RELAY_ON; end
                    MODE_RX: begin relays[RLY_PRE] = 1'b0; seq_mode = MODE_PREAMP_OFF; end
                    default: ;
                endcase
            end
        end
        r.relay_preamp    = relays[RLY_PRE];
        r.relay_antenna   = relays[RLY_ANT];
        r.relay_amplifier = relays[RLY_AMP];
        r.power_led       = leds[LED_PWR];
        r.ptt_led         = leds[LED_PTT];
        r.mode            = seq_mode;
        r.sample_source   = (seq_mode != MODE_STARTUP);
        modes_seen[seq_mode] = 1'b1;
        return r;
    endfunction

    // mostly back-to-back, some short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 25);
    endfunction

    // small values keep the averaged step delay short
    function automatic logic [SAMPLE_W-1:0] pot_sample();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return $urandom_range(0, 127);
        else if (roll < 92)
            return $urandom_range(0, 1023);
        else
            return roll[0] ? {SAMPLE_W{1'b1}} : '0;
    endfunction

    task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (want_v !== got_v) begin
            if (error_count < ERROR_PRINTS)
                $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
            error_count++;
        end
    endtask

    task automatic queue_tick(logic [SAMPLE_W-1:0] value, logic level);
        t_item it;
        it.cmd        = CMD_TICK;
        it.adc_sample = value;
        it.ptt_level  = level;
        pending_events_q.push_back(it);
    endtask

    task automatic queue_ptt(logic level);
        t_item it;
        it.cmd        = CMD_PTT;
        it.adc_sample = $urandom_range(0, 1023);
        it.ptt_level  = level;
        pending_events_q.push_back(it);
    endtask

    task automatic settle();
        while (pending_events_q.size() != 0 || i_valid || predicted_drive_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SUPPLY_THRESHOLD: seq_cfg.supply_threshold = data;
            CFG_GOOD_PERIODS: seq_cfg.good_periods_needed = data[GOOD_W-1:0];
            CFG_MINIMUM_DELAY: seq_cfg.minimum_delay = data;
            CFG_INITIAL_DELAY: seq_cfg.initial_delay = data;
            default: ;
        endcase
        cfg_writes++;
    endtask

    // pin edges followed by tick runs, with a share of arbitrary beats as noise
    task automatic run_phase(int n_beats);
        int queued;
        int run_len;
        queued = 0;
        while (queued < n_beats) begin
            if ($urandom_range(0, 99) < 85) begin
                if ($urandom_range(0, 99) < 80)
                    last_level = !last_level;
                queue_ptt(last_level);
                run_len = $urandom_range(0, 45);
                repeat (run_len) queue_tick(pot_sample(), $urandom_range(0, 1));
                queued += run_len + 1;
            end else begin
                if ($urandom_range(0, 1))
                    queue_ptt($urandom_range(0, 1));
                else
                    queue_tick($urandom_range(0, 1023), $urandom_range(0, 1));
                queued++;
            end
        end
        settle();
    endtask

    // driver: one beat per accepted handshake, random gaps between beats unless idle_off is set
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predicted_drive_q.push_back(next_relay_outputs(drv_item));
                beats_in++;
            end
            if (!i_valid || !o_stall) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_valid <= 1'b0;
                end else if (pending_events_q.size() != 0) begin
                    drv_item = pending_events_q.pop_front();
                    i_cmd        <= drv_item.cmd;
                    i_adc_sample <= drv_item.adc_sample;
                    i_ptt_level  <= drv_item.ptt_level;
                    i_valid      <= 1'b1;
                    src_gap = idle_off ? 0 : pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result beat, then decide the stall for the next cycle
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b1;
        end else begin
            if (o_valid && !i_stall) begin
                if (predicted_drive_q.size() == 0) begin
                    if (error_count < ERROR_PRINTS)
                        $error("result beat with nothing expected, mode %0d", o_mode);
                    error_count++;
                end else begin
                    want = predicted_drive_q.pop_front();
                    results_checked++;
                    check_field("relay_preamp", want.relay_preamp, o_relay_preamp);
                    check_field("relay_antenna", want.relay_antenna, o_relay_antenna);
                    check_field("relay_amplifier", want.relay_amplifier, o_relay_amplifier);
                    check_field("power_led", want.power_led, o_power_led);
                    check_field("ptt_led", want.ptt_led, o_ptt_led);
                    check_field("mode", want.mode, o_mode);
                    check_field("sample_source", want.sample_source, o_sample_source);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (holds_taken != holds_asked) begin
                holds_taken++;
                hold_left = HOLD_CYCLES - 1;
                i_stall <= 1'b1;
            end else if (idle_off) begin
                i_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                stall_left = pick_gap();
                if (stall_left > 0) begin
                    stall_left--;
                    i_stall <= 1'b1;
                end else begin
                    i_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, predicted_drive_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int                  d;
        int                  n;
        int                  loops;
        logic [SAMPLE_W-1:0] thr;
        seq_cfg.supply_threshold    = 10'd890;
        seq_cfg.good_periods_needed = 8'd8;
        seq_cfg.minimum_delay       = 10'd70;
        seq_cfg.initial_delay       = 10'd200;
        seq_mode         = MODE_STARTUP;
        seq_ticks        = '0;
        seq_good         = '0;
        pot_sum          = '0;
        pot_count        = '0;
        step_delay_ticks = seq_cfg.initial_delay;
        relays           = '0;
        leds             = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // startup at reset values: pin changes ignored, samples around the threshold
        queue_ptt(1'b0);
        queue_ptt(1'b1);
        queue_tick(10'd0, 1'b0);
        queue_tick(10'd1023, 1'b1);
        queue_tick(10'd889, 1'b0);
        queue_tick(10'd890, 1'b1);
        queue_tick(10'h2AA, 1'b0);
        queue_tick(10'h155, 1'b1);
        queue_ptt(1'b0);
        queue_tick(10'd891, 1'b0);
        settle();

        // highest threshold: nearly every sample is low across a full blink period
        write_reg(CFG_SUPPLY_THRESHOLD, 10'd1023);
        write_reg(CFG_GOOD_PERIODS, 10'd2);
        write_reg(CFG_INITIAL_DELAY, 10'd1023);
        repeat (200) begin
            if ($urandom_range(0, 9) == 0)
                queue_ptt($urandom_range(0, 1));
            queue_tick($urandom_range(0, 1023), $urandom_range(0, 1));
        end
        settle();

        // threshold zero: all good, but the needed count is out of reach
        write_reg(CFG_SUPPLY_THRESHOLD, 10'd0);
        write_reg(CFG_GOOD_PERIODS, 10'd255);
        write_reg(CFG_INITIAL_DELAY, 10'd1);
        write_reg(CFG_MINIMUM_DELAY, 10'd0);
        repeat (220) queue_tick($urandom_range(0, 1023), $urandom_range(0, 1));
        settle();

        // leave startup: upper data bits of the period count are dropped
        thr = $urandom_range(300, 900);
        write_reg(CFG_SUPPLY_THRESHOLD, thr);
        write_reg(CFG_GOOD_PERIODS, {2'b11, 8'd2});
        write_reg(CFG_INITIAL_DELAY, $urandom_range(1, 3));
        write_reg(CFG_MINIMUM_DELAY, $urandom_range(0, 20));
        loops = 0;
        while (seq_mode == MODE_STARTUP) begin
            // batch ends exactly on the period boundary
            n = BLINK_PERIOD_TICKS - seq_ticks;
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 99) < 8)
                    queue_ptt($urandom_range(0, 1));
                if (loops == 0 && (i == 0 || $urandom_range(0, 99) == 0))
                    queue_tick($urandom_range(0, thr - 1), $urandom_range(0, 1));
                else
                    queue_tick($urandom_range(thr, 1023), $urandom_range(0, 1));
            end
            settle();
            loops++;
        end

        // walk every relay transition on the initial delay
        d = seq_cfg.initial_delay;
        if (seq_mode == MODE_RELAY_ON) begin
            queue_ptt(1'b1);
            repeat (d) queue_tick(pot_sample(), 1'b1);
        end
        queue_ptt(1'b1);
        queue_ptt(1'b0);
        queue_ptt(1'b1);
        queue_ptt(1'b0);
        repeat (d) queue_tick(pot_sample(), 1'b0);
        queue_ptt(1'b1);
        queue_ptt(1'b0);
        repeat (d) queue_tick(pot_sample(), 1'b0);
        queue_ptt(1'b0);
        queue_ptt(1'b1);
        queue_ptt(1'b0);
        queue_ptt(1'b1);
        repeat (2 * d) queue_tick(pot_sample(), 1'b1);
        settle();
        last_level = 1'b1;

        for (int p = 0; p < RUN_PHASES; p++) begin
            if (p == 4) begin
                // largest minimum: step delay saturates, one full wait in each direction
                write_reg(CFG_MINIMUM_DELAY, 10'd1023);
                repeat (SAMPLES_PER_AVERAGE) queue_tick($urandom_range(0, 1023), 1'b0);
                queue_ptt(1'b0);
                repeat (1030) queue_tick($urandom_range(0, 1023), $urandom_range(0, 1));
                queue_ptt(1'b1);
                repeat (1030) queue_tick($urandom_range(0, 1023), $urandom_range(0, 1));
                settle();
                last_level = 1'b1;
            end
            case (p)
                0: write_reg(CFG_MINIMUM_DELAY, 10'd0);
                3: write_reg(CFG_MINIMUM_DELAY, 10'd3);
                default: write_reg(CFG_MINIMUM_DELAY, $urandom_range(0, 20 + 4 * p));
            endcase
            if (p == 0) begin
                // all-zero average with no minimum: timed steps stop until the count wraps
                repeat (SAMPLES_PER_AVERAGE) queue_tick(10'd0, 1'b1);
            end
            idle_off = (p == 2 || p == 5);
            if (p == 2)
                holds_asked++;
            run_phase(RANDOM_BEATS / RUN_PHASES);
        end
        idle_off = 1'b0;

        settle();
        repeat (10) @(posedge i_clk);
        if (predicted_drive_q.size() != 0) begin
            $error("%0d results never arrived", predicted_drive_q.size());
            error_count++;
        end
        $display("covered %0d beats, %0d results compared, %0d register writes",
                 beats_in, results_checked, cfg_writes);
        $display("mode codes reached %b, %0d field mismatches", modes_seen, error_count);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
